### rtl/core/gtmd_pkg.sv
package gtmd_pkg;

   localparam int TIME_BITS  = 24;
   localparam int DEPTH_BITS = 20;
   localparam int THR_BITS   = 20;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(750);
   // depth against threshold compare width
   localparam int CMP_BITS   = (DEPTH_BITS > THR_BITS) ? DEPTH_BITS : THR_BITS;

   localparam int DSUM_BITS = DEPTH_BITS + 1;
   localparam int PROD_BITS = TIME_BITS + DSUM_BITS;
   localparam int SUM_BITS  = TIME_BITS + DEPTH_BITS + 1;
   // dividend: integral plus half the duration, one bit of headroom
   localparam int NUM_BITS  = SUM_BITS + 1;
   localparam int ITER_BITS = $clog2(NUM_BITS);

   localparam int REQ_DATA_BITS = ((TIME_BITS + DEPTH_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((TIME_BITS + DEPTH_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // rsp_tuser bit positions
   localparam int USER_VALID_BIT = 0;
   localparam int USER_ERROR_BIT = 1;

   typedef struct packed {
      logic                 last;
      logic                 err;
      logic [DSUM_BITS-1:0] dsum;
      logic [TIME_BITS-1:0] delta;
   } entry_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_PREP,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

### rtl/core/gtmd_front.sv
module gtmd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [gtmd_pkg::THR_BITS-1:0]       csr_wr_data,
   input  logic                                accept,
   input  logic [gtmd_pkg::TIME_BITS-1:0]      sample_time,
   input  logic [gtmd_pkg::DEPTH_BITS-1:0]     sample_depth,
   input  logic                                last_sample,
   output gtmd_pkg::entry_type                 entry
);

   logic [gtmd_pkg::THR_BITS-1:0]   thr_ff, thr_in;
   logic [gtmd_pkg::TIME_BITS-1:0]  prev_time_ff, prev_time_in;
   logic [gtmd_pkg::DEPTH_BITS-1:0] prev_depth_ff, prev_depth_in;
   logic                            backwards;
   logic                            counted;

   always_comb begin
      backwards = sample_time < prev_time_ff;
      counted   = (gtmd_pkg::CMP_BITS'(sample_depth) > gtmd_pkg::CMP_BITS'(thr_ff)) ||
                  (gtmd_pkg::CMP_BITS'(prev_depth_ff) > gtmd_pkg::CMP_BITS'(thr_ff));

      entry.last  = last_sample;
      entry.err   = backwards;
      entry.dsum  = gtmd_pkg::DSUM_BITS'(sample_depth) + gtmd_pkg::DSUM_BITS'(prev_depth_ff);
      // a segment that is not counted, or runs backwards, contributes nothing
      entry.delta = (counted && !backwards) ? (sample_time - prev_time_ff) : '0;

      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      prev_time_in  = prev_time_ff;
      prev_depth_in = prev_depth_ff;
      if (accept) begin
         prev_time_in  = last_sample ? '0 : sample_time;
         prev_depth_in = last_sample ? '0 : sample_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= gtmd_pkg::THR_RESET;
         prev_time_ff  <= '0;
         prev_depth_ff <= '0;
      end else begin
         thr_ff        <= thr_in;
         prev_time_ff  <= prev_time_in;
         prev_depth_ff <= prev_depth_in;
      end
   end

endmodule

### rtl/core/gtmd_queue.sv
module gtmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gtmd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output gtmd_pkg::entry_type head_entry,
   output logic                empty
);

   gtmd_pkg::entry_type               slots_ff [gtmd_pkg::QUEUE_DEPTH];
   logic [gtmd_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [gtmd_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [gtmd_pkg::QUEUE_AW:0]       count_ff, count_in;

   always_comb begin
      full       = count_ff == (gtmd_pkg::QUEUE_AW+1)'(gtmd_pkg::QUEUE_DEPTH);
      empty      = count_ff == '0;
      head_entry = slots_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + (gtmd_pkg::QUEUE_AW+1)'(push) - (gtmd_pkg::QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/gtmd_back.sv
module gtmd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  gtmd_pkg::entry_type               head_entry,
   input  logic                              empty,
   output logic                              pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [gtmd_pkg::TIME_BITS-1:0]    out_duration,
   output logic [gtmd_pkg::DEPTH_BITS-1:0]   out_mean,
   output logic                              out_ok,
   output logic                              out_err
);

   localparam int TB = gtmd_pkg::TIME_BITS;
   localparam int DB = gtmd_pkg::DEPTH_BITS;
   localparam int SB = gtmd_pkg::SUM_BITS;
   localparam int NB = gtmd_pkg::NUM_BITS;
   localparam int IB = gtmd_pkg::ITER_BITS;
   localparam int PB = gtmd_pkg::PROD_BITS;

   gtmd_pkg::back_state_type state_ff, state_in;

   // multiply stage
   logic          p_valid_ff, p_valid_in;
   logic          p_last_ff, p_last_in;
   logic          p_err_ff, p_err_in;
   logic [TB-1:0] p_delta_ff, p_delta_in;
   logic [PB-1:0] prod_ff, prod_in;

   // dive accumulators
   logic [TB-1:0] dur_ff, dur_in;
   logic [SB-1:0] int_ff, int_in;
   logic          err_ff, err_in;

   // restoring divider: num_ff shifts dividend out and quotient in
   logic [NB-1:0] num_ff, num_in;
   logic [TB-1:0] rem_ff, rem_in;
   logic [IB-1:0] iter_ff, iter_in;

   logic          o_valid_ff, o_valid_in;
   logic [TB-1:0] o_dur_ff, o_dur_in;
   logic [DB-1:0] o_mean_ff, o_mean_in;
   logic          o_ok_ff, o_ok_in;
   logic          o_err_ff, o_err_in;

   logic [TB:0]   dur_sum;
   logic [SB:0]   int_sum;
   logic [TB:0]   trial;
   logic          fits;

   always_comb begin
      state_in   = state_ff;
      dur_in     = dur_ff;
      int_in     = int_ff;
      err_in     = err_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      iter_in    = iter_ff;
      o_valid_in = o_valid_ff && !out_ready;
      o_dur_in   = o_dur_ff;
      o_mean_in  = o_mean_ff;
      o_ok_in    = o_ok_ff;
      o_err_in   = o_err_ff;

      // a last sample in the multiply stage blocks the next pop until the dive is closed
      pop        = (state_ff == gtmd_pkg::BK_RUN) && !empty && !(p_valid_ff && p_last_ff);
      p_valid_in = pop;
      p_last_in  = head_entry.last;
      p_err_in   = head_entry.err;
      p_delta_in = head_entry.delta;
      prod_in    = PB'(head_entry.delta) * PB'(head_entry.dsum);

      dur_sum = (TB+1)'(dur_ff) + (TB+1)'(p_delta_ff);
      int_sum = (SB+1)'(int_ff) + (SB+1)'(prod_ff >> 1);
      trial   = {rem_ff, num_ff[NB-1]};
      fits    = trial >= (TB+1)'(dur_ff);

      case (state_ff)
         gtmd_pkg::BK_RUN: begin
            if (p_valid_ff) begin
               dur_in = dur_sum[TB] ? '1 : dur_sum[TB-1:0];
               int_in = int_sum[SB] ? '1 : int_sum[SB-1:0];
               err_in = err_ff | p_err_ff;
               if (p_last_ff) begin
                  state_in = gtmd_pkg::BK_PREP;
               end
            end
         end
         gtmd_pkg::BK_PREP: begin
            num_in   = NB'(int_ff) + NB'(dur_ff >> 1);
            rem_in   = '0;
            iter_in  = '0;
            state_in = gtmd_pkg::BK_DIV;
         end
         gtmd_pkg::BK_DIV: begin
            rem_in  = fits ? TB'(trial - (TB+1)'(dur_ff)) : trial[TB-1:0];
            num_in  = {num_ff[NB-2:0], fits};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IB'(NB - 1)) begin
               state_in = gtmd_pkg::BK_DONE;
            end
         end
         gtmd_pkg::BK_DONE: begin
            if (!o_valid_ff || out_ready) begin
               o_valid_in = 1'b1;
               o_dur_in   = dur_ff;
               o_ok_in    = dur_ff != '0;
               o_err_in   = err_ff;
               if (dur_ff == '0) begin
                  o_mean_in = '0;
               end else if (|num_ff[NB-1:DB]) begin
                  o_mean_in = '1;
               end else begin
                  o_mean_in = num_ff[DB-1:0];
               end
               dur_in   = '0;
               int_in   = '0;
               err_in   = 1'b0;
               state_in = gtmd_pkg::BK_RUN;
            end
         end
         default: begin
            state_in = gtmd_pkg::BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gtmd_pkg::BK_RUN;
         p_valid_ff <= 1'b0;
         dur_ff     <= '0;
         int_ff     <= '0;
         err_ff     <= 1'b0;
         iter_ff    <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_valid_ff <= p_valid_in;
         dur_ff     <= dur_in;
         int_ff     <= int_in;
         err_ff     <= err_in;
         iter_ff    <= iter_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_last_ff  <= p_last_in;
      p_err_ff   <= p_err_in;
      p_delta_ff <= p_delta_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      o_dur_ff   <= o_dur_in;
      o_mean_ff  <= o_mean_in;
      o_ok_ff    <= o_ok_in;
      o_err_ff   <= o_err_in;
   end

   assign out_valid    = o_valid_ff;
   assign out_duration = o_dur_ff;
   assign out_mean     = o_mean_ff;
   assign out_ok       = o_ok_ff;
   assign out_err      = o_err_ff;

endmodule

### rtl/core/gated_trapezoid_mean_depth.sv
// Time-weighted mean depth of a dive. Each transaction on req carries one
// sample (time in s, depth in mm, tlast on the final sample of the dive). A
// segment between consecutive samples counts when either end is deeper than
// the threshold held in the csr register (reset 750 mm); counted segments add
// to the duration and to a trapezoidal depth-time integral, both saturating.
// A time that goes backwards gives a zero-length segment and sets the error
// flag. After the last sample one rsp transaction carries the duration and
// the mean depth rounded half up (saturated at full scale, 0 with the valid
// flag clear when the duration is zero); the dive state then returns to zero.
// Samples are taken at one per cycle while the queue is not full: a 4-entry
// queue sits in front of a multiply stage and accumulator. Closing a dive
// occupies the back end for a setup step, a restoring divider at one quotient
// bit per cycle, and a load of the output register, which waits while a
// previous result is stalled. Samples of the next dive keep entering until
// the queue fills.
module gated_trapezoid_mean_depth (
   input  logic                                     clock,
   input  logic                                     reset,
   // sample_time, sample_depth, zero fill
   input  logic [gtmd_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   input  logic                                     req_tlast,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // underwater_duration, mean_depth, zero fill
   output logic [gtmd_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // result_valid, order_error
   output logic [gtmd_pkg::RSP_USER_BITS-1:0]       rsp_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic                                     csr_wr_en,
   input  logic [gtmd_pkg::THR_BITS-1:0]            csr_wr_data
);

   localparam int TB = gtmd_pkg::TIME_BITS;
   localparam int DB = gtmd_pkg::DEPTH_BITS;

   gtmd_pkg::entry_type push_entry;
   gtmd_pkg::entry_type head_entry;
   logic                full;
   logic                empty;
   logic                pop;
   logic                accept;
   logic [TB-1:0]       out_duration;
   logic [DB-1:0]       out_mean;
   logic                out_ok;
   logic                out_err;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   gtmd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .sample_time  (req_tdata[TB-1:0]),
      .sample_depth (req_tdata[TB+DB-1:TB]),
      .last_sample  (req_tlast),
      .entry        (push_entry)
   );

   gtmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_entry (head_entry),
      .empty      (empty)
   );

   gtmd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .empty        (empty),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_duration (out_duration),
      .out_mean     (out_mean),
      .out_ok       (out_ok),
      .out_err      (out_err)
   );

   assign rsp_tdata = gtmd_pkg::RSP_DATA_BITS'({out_mean, out_duration});
   assign rsp_tuser = {out_err, out_ok};

endmodule

### rtl/core/gtmd_checker.sv
module gtmd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic [gtmd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic [gtmd_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   localparam int TB = gtmd_pkg::TIME_BITS;
   localparam int DB = gtmd_pkg::DEPTH_BITS;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // no duration means no mean
   a_zero_dur: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[gtmd_pkg::USER_VALID_BIT] |->
         rsp_tdata[TB-1:0] == '0 && rsp_tdata[TB+DB-1:TB] == '0)
      else $error("invalid result with nonzero duration or mean");

   a_valid_dur: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[gtmd_pkg::USER_VALID_BIT] |-> rsp_tdata[TB-1:0] != '0)
      else $error("valid result with zero duration");

   // first edge out of reset
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind gated_trapezoid_mean_depth gtmd_checker u_checker (.*);
